// File: hdl/integer_to_ascii_radix_macros.svh
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define I2A_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/i2a_pkg.sv
package i2a_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int VALUE_W        = 32;
	localparam int RADIX_W        = 5;
	localparam int CHAR_W         = 8;
	localparam int POS_W          = 6;
	localparam int DIGIT_W        = 4;
	localparam int SHAMT_W        = 3;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFS = 8'h37;
	localparam logic [CHAR_W-1:0] CHAR_MINUS     = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NINE      = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_F   = 8'h46;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_signed;
		logic [RADIX_W-1:0] radix;
	} num_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic [POS_W-1:0]  position;
		logic              last;
	} sym_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [VALUE_W-1:0] mag;
		logic               neg;
		logic [RADIX_W-1:0] radix;
		logic               pow2;
		logic [SHAMT_W-1:0] shamt;
	} job_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_ALPHA_OFS + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage

// File: hdl/i2a_front.sv
module i2a_front #(
	parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  i2a_pkg::num_t number,
	output logic          job_valid,
	input  logic          job_ready,
	output i2a_pkg::job_t job
);
	import i2a_pkg::*;

	logic [VALUE_BITS-1:0] v;
	logic [VALUE_BITS-1:0] mag;
	logic                  neg;
	logic [RADIX_W-1:0]    radix;
	job_t                  cls;

	job_t       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		v   = number.value[VALUE_BITS-1:0];
		neg = number.is_signed & v[VALUE_BITS-1];
		mag = neg ? (~v + 1'b1) : v;
		if (number.radix < RADIX_MIN) begin
			radix = RADIX_MIN;
		end else if (number.radix > RADIX_MAX) begin
			radix = RADIX_MAX;
		end else begin
			radix = number.radix;
		end
		cls.mag   = VALUE_W'(mag);
		cls.neg   = neg;
		cls.radix = radix;
		case (radix)
			5'd2: begin
				cls.pow2  = 1'b1;
				cls.shamt = 3'd1;
			end
			5'd4: begin
				cls.pow2  = 1'b1;
				cls.shamt = 3'd2;
			end
			5'd8: begin
				cls.pow2  = 1'b1;
				cls.shamt = 3'd3;
			end
			5'd16: begin
				cls.pow2  = 1'b1;
				cls.shamt = 3'd4;
			end
			default: begin
				cls.pow2  = 1'b0;
				cls.shamt = 3'd0;
			end
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job       = q_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = job_valid && job_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: hdl/i2a_back.sv
module i2a_back #(
	parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  i2a_pkg::job_t job,
	input  logic          pop,
	output logic          empty,
	output i2a_pkg::sym_t symbol
);
	import i2a_pkg::*;

	localparam int STEPS      = 8;
	localparam int DIV_CYCLES = (VALUE_BITS + STEPS - 1) / STEPS;
	localparam int PW         = DIV_CYCLES * STEPS;
	localparam int CYC_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t             state_q;
	logic [PW-1:0]      mag_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [RADIX_W-1:0] radix_q;
	logic               pow2_q;
	logic [SHAMT_W-1:0] shamt_q;
	logic               minus_q;
	logic [CYC_W-1:0]   cyc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [POS_W-1:0]   pos_q;
	logic [DIGIT_W-1:0] stk_q [VALUE_BITS];
	logic               ovalid_q;
	sym_t               out_q;

	logic [RADIX_W-1:0] r_t;
	logic [PW-1:0]      m_t;
	logic               qb;
	logic [DIGIT_W-1:0] digit;
	logic [PW-1:0]      next_mag;
	logic               digit_done;
	logic               ofree;
	logic               emit;
	logic               push_dig;

	// eight restoring-division steps per cycle
	always_comb begin
		r_t = RADIX_W'(rem_q);
		m_t = mag_q;
		qb  = 1'b0;
		for (int i = 0; i < STEPS; i++) begin
			r_t = {r_t[DIGIT_W-1:0], m_t[PW-1]};
			qb  = (r_t >= radix_q);
			if (qb) begin
				r_t = r_t - radix_q;
			end
			m_t = {m_t[PW-2:0], qb};
		end
	end

	always_comb begin
		if (pow2_q) begin
			digit    = mag_q[DIGIT_W-1:0] & (radix_q[DIGIT_W-1:0] - 4'd1);
			next_mag = mag_q >> shamt_q;
		end else begin
			digit    = r_t[DIGIT_W-1:0];
			next_mag = m_t;
		end
		digit_done = pow2_q || (cyc_q == CYC_W'(DIV_CYCLES - 1));
	end

	assign job_ready = (state_q == ST_IDLE);
	assign ofree     = !ovalid_q || pop;
	assign emit      = (state_q == ST_EMIT) && ofree;
	assign push_dig  = (state_q == ST_CONV) && digit_done;
	assign empty     = !ovalid_q;
	assign symbol    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			cyc_q    <= '0;
			pos_q    <= '0;
			minus_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_CONV;
						cnt_q   <= '0;
						cyc_q   <= '0;
						pos_q   <= '0;
						minus_q <= job.neg;
					end
				end
				ST_CONV: begin
					if (digit_done) begin
						cnt_q <= cnt_q + 1'b1;
						cyc_q <= '0;
						if (next_mag == '0) begin
							state_q <= ST_EMIT;
						end
					end else begin
						cyc_q <= cyc_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (ofree) begin
						pos_q <= pos_q + 1'b1;
						if (minus_q) begin
							minus_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q - 1'b1;
							if (cnt_q == CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			mag_q   <= PW'(job.mag[VALUE_BITS-1:0]);
			rem_q   <= '0;
			radix_q <= job.radix;
			pow2_q  <= job.pow2;
			shamt_q <= job.shamt;
		end else if (state_q == ST_CONV) begin
			if (digit_done) begin
				mag_q <= next_mag;
				rem_q <= '0;
			end else begin
				mag_q <= m_t;
				rem_q <= r_t[DIGIT_W-1:0];
			end
		end
	end

	// digit stack: pushed least significant first, popped from the top
	always_ff @(posedge clk) begin
		if (push_dig) begin
			stk_q[0] <= digit;
			for (int i = 1; i < VALUE_BITS; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (emit && !minus_q) begin
			for (int i = 0; i < VALUE_BITS - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.position <= pos_q;
			if (minus_q) begin
				out_q.character <= CHAR_MINUS;
				out_q.last      <= 1'b0;
			end else begin
				out_q.character <= digit_char(stk_q[0]);
				out_q.last      <= (cnt_q == CNT_W'(1));
			end
		end
	end

endmodule

// File: hdl/integer_to_ascii_radix.sv
// channel   dir  handshake               payload
// number    in   push / full             value, is_signed, radix
// symbol    out  pop / empty             character, position, last
//
// One item is converted at a time; up to two more wait in a two-entry queue.
// Radix 2, 4, 8 or 16: each digit by shift and mask. Other radices: each digit
// from the 8-step-per-cycle restoring divider. The digits are then emitted as
// characters from the digit stack, a minus sign first for negative values.
// Output register holds one character and refills in the cycle it is popped.
// Reset empties all queues; no clearing pass.
module integer_to_ascii_radix #(
	parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  i2a_pkg::num_t number,
	output logic          empty,
	input  logic          pop,
	output i2a_pkg::sym_t symbol
);
	import i2a_pkg::*;

	logic job_valid;
	logic job_ready;
	job_t job;

	i2a_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.number    (number),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	i2a_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.pop       (pop),
		.empty     (empty),
		.symbol    (symbol)
	);

endmodule

// File: hdl/i2a_checker.sv
`include "integer_to_ascii_radix_macros.svh"

module i2a_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          pop,
	input logic          empty,
	input i2a_pkg::sym_t symbol
);
	import i2a_pkg::*;

	`I2A_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(symbol), "held item changed")
	`I2A_ASSERT_NEXT(a_follow, pop && !empty && !symbol.last, !empty, "gap inside a number")
	`I2A_ASSERT_NOW(a_minus, !empty && symbol.character == CHAR_MINUS, symbol.position == 6'd0 && !symbol.last, "misplaced minus")
	`I2A_ASSERT_NOW(a_char, !empty, symbol.character == CHAR_MINUS || (symbol.character >= CHAR_ZERO && symbol.character <= CHAR_NINE) || (symbol.character >= CHAR_UPPER_A && symbol.character <= CHAR_UPPER_F), "bad character")

endmodule

bind integer_to_ascii_radix i2a_checker u_i2a_checker (.*);

// File: test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import i2a_pkg::*;

	localparam int VALUE_BITS     = VALUE_BITS_DEF;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_NUMBERS = 92;
	localparam int REPORT_MAX     = 10;

	class char_scoreboard;
		sym_t expected_chars[$];
		int   numbers_seen;
		int   negatives_seen;
		int   chars_checked;
		int   mismatches;

		// spell one accepted number into its expected characters
		function void note_number(num_t n);
			logic [VALUE_BITS-1:0] v;
			logic [VALUE_BITS:0]   mag;
			logic [RADIX_W-1:0]    base;
			logic [DIGIT_W-1:0]    digits[$];
			logic [CHAR_W-1:0]     ch;
			bit                    minus;
			int                    total;
			int                    k;
			sym_t                  s;
			v = n.value[VALUE_BITS-1:0];
			if (n.radix < RADIX_MIN) begin
				base = RADIX_MIN;
			end else if (n.radix > RADIX_MAX) begin
				base = RADIX_MAX;
			end else begin
				base = n.radix;
			end
			minus = n.is_signed && v[VALUE_BITS-1];
			// one bit wider so the most negative value does not overflow
			mag = minus ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
			do begin
				digits.push_front(DIGIT_W'(mag % base));
				mag = mag / base;
			end while (mag != 0);
			total = digits.size() + (minus ? 1 : 0);
			k = 0;
			if (minus) begin
				s.character = CHAR_MINUS;
				s.position  = POS_W'(k);
				s.last      = (k == total - 1);
				expected_chars.push_back(s);
				k++;
				negatives_seen++;
			end
			foreach (digits[i]) begin
				if (digits[i] < 10) begin
					ch = CHAR_ZERO + CHAR_W'(digits[i]);
				end else begin
					ch = CHAR_ALPHA_OFS + CHAR_W'(digits[i]);
				end
				s.character = ch;
				s.position  = POS_W'(k);
				s.last      = (k == total - 1);
				expected_chars.push_back(s);
				k++;
			end
			numbers_seen++;
		endfunction

		function void check_symbol(sym_t got);
			sym_t want;
			chars_checked++;
			if (expected_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("%0t: unexpected character %h pos %0d last %0d", $time,
						got.character, got.position, got.last);
				end
				return;
			end
			want = expected_chars.pop_front();
			if (got.character !== want.character || got.position !== want.position ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("%0t: character mismatch: exp %h pos %0d last %0d, got %h pos %0d last %0d",
						$time, want.character, want.position, want.last,
						got.character, got.position, got.last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	num_t number;
	logic empty;
	logic pop;
	sym_t symbol;

	char_scoreboard book = new();
	bit gaps_on;
	int cycles;
	int stall_cycles;

	integer_to_ascii_radix #(
		.VALUE_BITS(VALUE_BITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.number(number),
		.empty (empty),
		.pop   (pop),
		.symbol(symbol)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (arst_n && pop && !empty) begin
			book.check_symbol(symbol);
		end
		if (arst_n && push && full) begin
			stall_cycles++;
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters outstanding", cycles,
				book.expected_chars.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// result side: random pops, plus one long hold-off to back the block up
	initial begin : receiver
		bit held;
		int hold_left;
		pop = 1'b0;
		held = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (!held && book.numbers_seen >= 30) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= arst_n && !(gaps_on && $urandom_range(0, 99) < 8);
			end
		end
	end

	function automatic num_t make_number(logic [VALUE_W-1:0] v, logic sgn,
			logic [RADIX_W-1:0] r);
		num_t n;
		n.value = v;
		n.is_signed = sgn;
		n.radix = r;
		return n;
	endfunction

	function automatic num_t random_number();
		logic [VALUE_W-1:0] v;
		logic [RADIX_W-1:0] r;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 40);
			1: v = -VALUE_W'($urandom_range(1, 40));
			2: v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
			3: v = {1'b1, {(VALUE_W - 1){1'b0}}} ^ VALUE_W'($urandom_range(0, 3));
			default: v = $urandom();
		endcase
		if ($urandom_range(0, 99) < 85) begin
			r = RADIX_W'($urandom_range(2, 16));
		end else begin
			r = RADIX_W'($urandom_range(0, 31));
		end
		return make_number(v, 1'($urandom_range(0, 1)), r);
	endfunction

	// called and returns at a falling edge; push stays high into the next call
	task automatic send_number(input num_t n);
		while (gaps_on && $urandom_range(0, 99) < 8) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		number <= n;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		book.note_number(n);
		@(negedge clk);
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		push = 1'b0;
		number = '0;
		gaps_on = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero, extremes, saturated radices, letters, most negative value
		send_number(make_number(32'd0, 1'b0, 5'd10));
		send_number(make_number(32'd0, 1'b1, 5'd2));
		send_number(make_number(32'hFFFF_FFFF, 1'b0, 5'd2));
		send_number(make_number(32'hFFFF_FFFF, 1'b1, 5'd2));
		send_number(make_number(32'hFFFF_FFFF, 1'b0, 5'd10));
		send_number(make_number(32'h8000_0000, 1'b1, 5'd2));
		send_number(make_number(32'h8000_0000, 1'b1, 5'd10));
		send_number(make_number(32'h8000_0000, 1'b0, 5'd16));
		send_number(make_number(32'h7FFF_FFFF, 1'b1, 5'd10));
		send_number(make_number(32'hFEDC_BA98, 1'b0, 5'd16));
		send_number(make_number(32'h0123_4567, 1'b0, 5'd0));
		send_number(make_number(32'd5, 1'b0, 5'd1));
		send_number(make_number(32'hABCD_EF01, 1'b0, 5'd17));
		send_number(make_number(32'hABCD_EF01, 1'b1, 5'd31));
		send_number(make_number(32'd12345, 1'b0, 5'd10));
		send_number(make_number(-32'sd12345, 1'b1, 5'd10));
		send_number(make_number(32'hFFFF_FFFF, 1'b0, 5'd3));
		send_number(make_number(32'd35, 1'b0, 5'd5));
		send_number(make_number(32'd1000, 1'b1, 5'd7));
		send_number(make_number(32'h7FFF_FFFF, 1'b0, 5'd11));
		send_number(make_number(32'hDEAD_BEEF, 1'b1, 5'd13));
		send_number(make_number(32'h7777_7777, 1'b0, 5'd8));
		send_number(make_number(32'd15, 1'b0, 5'd15));

		for (i = 0; i < RANDOM_NUMBERS; i++) begin
			gaps_on = !(i >= 50 && i < 80);
			send_number(random_number());
		end
		gaps_on = 1'b1;
		push <= 1'b0;

		while (book.expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d numbers (%0d negative) into %0d characters over %0d cycles",
			book.numbers_seen, book.negatives_seen, book.chars_checked, cycles);
		$display("input held back by a full block for %0d cycles; %0d mismatches",
			stall_cycles, book.mismatches);
		if (book.mismatches == 0 && book.expected_chars.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
